// ===== hdl/lkvt_pkg.sv =====
// Package for the linear key-value table.
// Holds default sizes, result field widths and status/opcode codes.
// No dependencies.
`default_nettype none

package lkvt_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int STATUS_BITS   = 3;
  localparam int SLOT_OUT_BITS = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/linear_key_value_table.sv =====
// Sequence: the scan reads the occupied slots in order, a compare stage checks each
//   key read, and a resolve step registers the result; a hit ends the scan early.
// Flow: one transaction at a time; a new request is stalled until the previous one
//   has resolved; the scan uses the single key compare fed from one memory read port.
// Reset: rst_n low (synchronous) empties the table and clears the sequencer and the
//   output valid flag; slot contents are left as they are and never read. Uses lkvt_pkg.
`default_nettype none

module linear_key_value_table #(
  parameter int ENTRIES    = lkvt_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvt_pkg::DEF_VALUE_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // request channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   in_opcode,
  input  wire  [KEY_BITS-1:0]                   in_key,
  input  wire  [VALUE_BITS-1:0]                 in_new_value,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [lkvt_pkg::STATUS_BITS-1:0]      out_status,
  output logic [VALUE_BITS-1:0]                 out_found_value,
  output logic [lkvt_pkg::SLOT_OUT_BITS-1:0]    out_slot_index
);

  // CW holds a count 0..ENTRIES, IW addresses a slot.
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW = lkvt_pkg::SLOT_OUT_BITS + IW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // slot storage, one read port shared by key and value arrays
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         used_cnt_r;

  // latched request
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // scan pipeline: read stage address and compare stage data
  logic [CW-1:0]         rd_idx_r;
  logic                  cmp_vld_r;
  logic [IW-1:0]         cmp_idx_r;
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  // scan outcome
  logic                  hit_r;
  logic [IW-1:0]         hit_idx_r;
  logic [VALUE_BITS-1:0] hit_val_r;

  // output register
  logic                               out_valid_r;
  logic [lkvt_pkg::STATUS_BITS-1:0]   out_status_r;
  logic [VALUE_BITS-1:0]              out_found_r;
  logic [IW-1:0]                      out_idx_r;

  logic            in_take;
  logic            issue;
  logic            match;
  logic            out_free;
  logic            resolve;
  logic            tbl_full;
  logic            key_we;
  logic            val_we;
  logic [IW-1:0]   wr_idx;
  logic [lkvt_pkg::STATUS_BITS-1:0] res_status;
  logic [VALUE_BITS-1:0]            res_found;
  logic [IW-1:0]                    res_idx;
  logic [XW-1:0]                    slot_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // issue a read while there are occupied slots left to visit
  assign issue = (state_r == S_SCAN) && (rd_idx_r < used_cnt_r);
  assign match = cmp_vld_r && (key_rd_r == key_r);

  assign out_free = !out_valid_r || !out_stall;
  assign resolve  = (state_r == S_DONE) && out_free;
  assign tbl_full = (used_cnt_r == CW'(ENTRIES));

  // resolve: decide result and the write-back, done once on leaving S_DONE
  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = hit_idx_r;
    res_status = lkvt_pkg::ST_MISS;
    res_found  = '0;
    res_idx    = '0;
    if (op_r == lkvt_pkg::OP_INSERT) begin
      if (hit_r) begin
        val_we     = resolve;
        res_status = lkvt_pkg::ST_UPDATED;
        res_idx    = hit_idx_r;
      end else if (!tbl_full) begin
        key_we     = resolve;
        val_we     = resolve;
        wr_idx     = used_cnt_r[IW-1:0];
        res_status = lkvt_pkg::ST_APPENDED;
        res_idx    = used_cnt_r[IW-1:0];
      end else begin
        res_status = lkvt_pkg::ST_FULL;
      end
    end else begin
      if (hit_r) begin
        res_status = lkvt_pkg::ST_HIT;
        res_found  = hit_val_r;
        res_idx    = hit_idx_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // stop at the first match, or once the last slot has been compared
        if (match || !issue) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (key_we) used_cnt_r <= CW'(used_cnt_r + 1'b1);
      cmp_vld_r <= issue;
      if (resolve) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_opcode;
      key_r    <= in_key;
      val_r    <= in_new_value;
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r <= CW'(rd_idx_r + 1'b1);
    end
    cmp_idx_r <= rd_idx_r[IW-1:0];
    if ((state_r == S_SCAN) && (match || !issue)) begin
      hit_r     <= match;
      hit_idx_r <= cmp_idx_r;
      hit_val_r <= val_rd_r;
    end
    if (resolve) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_idx_r    <= res_idx;
    end
  end

  // slot memories: registered read, single write port each
  always_ff @(posedge clk) begin
    if (issue) begin
      key_rd_r <= key_mem[rd_idx_r[IW-1:0]];
      val_rd_r <= val_mem[rd_idx_r[IW-1:0]];
    end
    if (key_we) key_mem[wr_idx] <= key_r;
    if (val_we) val_mem[wr_idx] <= val_r;
  end

  assign slot_ext        = XW'(out_idx_r);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_slot_index  = slot_ext[lkvt_pkg::SLOT_OUT_BITS-1:0];

  // table never holds more than its capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= CW'(ENTRIES))
    else $error("used count above capacity");

  // the count only ever grows by one slot
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(used_cnt_r) |-> (used_cnt_r == CW'($past(used_cnt_r) + 1'b1)))
    else $error("used count changed by other than one");

  // a resolved transaction always lands in the output register
  a_resolve_out: assert property (@(posedge clk) disable iff (!rst_n)
    resolve |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("resolved transaction not presented");

  // a lookup never writes the table
  a_lookup_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == lkvt_pkg::OP_LOOKUP) |-> (!key_we && !val_we))
    else $error("lookup wrote the table");

endmodule

`default_nettype wire
